// ===== hdl/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Line position centroid package
// Widths, reset values and register indexes shared by the centroid core and
// its serial divider.
// ----------------------------------------------------------------------------
package lpc_pkg;

   localparam int NUM_SENSORS_DEF = 8;

   localparam int SAMPLE_W  = 12;
   localparam int OUT_W     = 10;
   localparam int NORM_W    = 11;
   localparam int CHAN_W    = 4;
   localparam int ERR_W     = 16;
   localparam int WSUM_W    = 20;
   localparam int VSUM_W    = 15;
   localparam int WEIGHT_W  = 8;

   localparam int DIV_NUM_W = WSUM_W + 8;
   localparam int DIV_DEN_W = VSUM_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [SAMPLE_W-1:0] IN_LOW_RST   = 12'd30;
   localparam logic [SAMPLE_W-1:0] IN_HIGH_RST  = 12'd2000;
   localparam logic [OUT_W-1:0]    OUT_LOW_RST  = 10'd0;
   localparam logic [OUT_W-1:0]    OUT_HIGH_RST = 10'd100;
   localparam logic [CHAN_W-1:0]   CHAN_OFF_RST = 4'd3;

   localparam logic [WEIGHT_W-1:0] WEIGHT_BIAS = 8'd28;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IN_LOW    = 3'd0,
      CSR_IN_HIGH   = 3'd1,
      CSR_OUT_LOW   = 3'd2,
      CSR_OUT_HIGH  = 3'd3,
      CSR_CHAN_OFF  = 3'd4
   } csr_reg_type;

endpackage

// ===== hdl/lpc_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Unsigned restoring divider, one quotient bit per cycle, NUM_W quotient
// bits per division. The quotient is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module lpc_div #(
   parameter int NUM_W = lpc_pkg::DIV_NUM_W,
   parameter int DEN_W = lpc_pkg::DIV_DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [NUM_W-1:0] quo_ff;

   logic [DEN_W:0]   trial;
   logic             ge;
   logic [DEN_W:0]   diff;
   logic [DEN_W-1:0] rem_in;
   logic [NUM_W-1:0] quo_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      ge     = (trial >= {1'b0, den_ff});
      diff   = trial - {1'b0, den_ff};
      rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_in = {quo_ff[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            den_ff  <= den;
            quo_ff  <= num;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ===== hdl/line_position_centroid_core.sv =====
// ----------------------------------------------------------------------------
// Line position centroid core
// Normalises line-sensor samples and forms the weighted centroid of a scan.
// ----------------------------------------------------------------------------
// One item on req_ carries one raw ADC sample of the selected sensor. Each
// item gives one item on rsp_: the normalised sample, the mux channel for the
// next sample, and on the last sensor of a scan (rsp_tlast) the line error in
// signed Q8.8, with rsp_tuser flagging an empty line.
// Items are handled one at a time; the next item can be accepted from the
// cycle in which rsp_tvalid rises. Each item passes through a shift-add
// multiply over the bits of the sample offset, the bit-serial divider (one
// quotient bit per cycle over 28 bits), then steps to saturate, accumulate
// and load the output. The last item of a scan, when the sample sum is not
// zero, makes a further pass through the same divider for the centroid
// quotient.
// req_tready is high only while the core is idle and out of reset. A finished
// result waits in the output register while the next sample is already being
// taken; if the receiver stalls with a result pending, the next result holds
// inside the core until the register frees.
// Reset (synchronous) clears the scan index and the sums and loads the
// default map registers. csr_ writes take effect at once and belong to idle
// periods only.
// ----------------------------------------------------------------------------
module line_position_centroid_core #(
   parameter int NUM_SENSORS = lpc_pkg::NUM_SENSORS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,   // sample[11:0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,   // normalized, next_channel, line_error
   output logic                           rsp_tlast,
   output logic                           rsp_tuser,   // no_line
   input  logic                           csr_we,
   input  logic [lpc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [lpc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
   localparam int SW    = lpc_pkg::SAMPLE_W;
   localparam int OW    = lpc_pkg::OUT_W;
   localparam int NW    = lpc_pkg::NORM_W;
   localparam int CW    = lpc_pkg::CHAN_W;
   localparam int EW    = lpc_pkg::ERR_W;
   localparam int WSW   = lpc_pkg::WSUM_W;
   localparam int VSW   = lpc_pkg::VSUM_W;
   localparam int WTW   = lpc_pkg::WEIGHT_W;
   localparam int DNUMW = lpc_pkg::DIV_NUM_W;
   localparam int DDENW = lpc_pkg::DIV_DEN_W;
   localparam int PW    = SW + OW;
   localparam int WPW   = NW + WTW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_NORM,
      ST_WMUL,
      ST_ACC,
      ST_LAST,
      ST_DIV_ERR,
      ST_OUT
   } state_type;

   state_type state_ff;

   logic [SW-1:0] in_low_ff;
   logic [SW-1:0] in_high_ff;
   logic [OW-1:0] out_low_ff;
   logic [OW-1:0] out_high_ff;
   logic [CW-1:0] chan_off_ff;

   logic [IDX_W-1:0]      idx_ff;
   logic signed [WSW-1:0] ws_ff;
   logic signed [VSW-1:0] vs_ff;

   logic [SW-1:0]          mplier_ff;
   logic [PW-1:0]          mcand_ff;
   logic [PW-1:0]          prod_ff;
   logic                   qneg_ff;
   logic [SW-1:0]          span_ff;
   logic signed [NW-1:0]   v_ff;
   logic signed [WPW-1:0]  wprod_ff;
   logic                   eneg_ff;
   logic                   done_ff;
   logic                   noline_ff;
   logic [EW-1:0]          err_ff;

   logic                   rsp_valid_ff;
   logic [NW-1:0]          rsp_norm_ff;
   logic [CW-1:0]          rsp_chan_ff;
   logic [EW-1:0]          rsp_err_ff;
   logic                   rsp_last_ff;
   logic                   rsp_noline_ff;

   logic [SW:0]    d_s;
   logic [SW-1:0]  d_mag;
   logic [OW:0]    m_s;
   logic [OW-1:0]  m_mag;
   logic [SW:0]    sp_s;
   logic [SW-1:0]  sp_mag;
   logic           sp_neg;

   logic             div_start;
   logic [DNUMW-1:0] div_num;
   logic [DDENW-1:0] div_den;
   logic             div_done;
   logic [DNUMW-1:0] div_quot;

   logic [PW:0]           q_s;
   logic [PW+1:0]         v_full;
   logic signed [NW-1:0]  v_sat;
   logic [WTW-1:0]        weight;
   logic [WSW-1:0]        ws_mag;
   logic [VSW-1:0]        vs_mag;
   logic                  last;
   logic [IDX_W-1:0]      next_idx;
   logic [EW-1:0]         err_sat;
   logic                  out_free;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_low_ff   <= lpc_pkg::IN_LOW_RST;
         in_high_ff  <= lpc_pkg::IN_HIGH_RST;
         out_low_ff  <= lpc_pkg::OUT_LOW_RST;
         out_high_ff <= lpc_pkg::OUT_HIGH_RST;
         chan_off_ff <= lpc_pkg::CHAN_OFF_RST;
      end else if (csr_we) begin
         case (lpc_pkg::csr_reg_type'(csr_addr))
            lpc_pkg::CSR_IN_LOW:   in_low_ff   <= csr_wdata[SW-1:0];
            lpc_pkg::CSR_IN_HIGH:  in_high_ff  <= csr_wdata[SW-1:0];
            lpc_pkg::CSR_OUT_LOW:  out_low_ff  <= csr_wdata[OW-1:0];
            lpc_pkg::CSR_OUT_HIGH: out_high_ff <= csr_wdata[OW-1:0];
            lpc_pkg::CSR_CHAN_OFF: chan_off_ff <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      d_s    = {1'b0, req_tdata[SW-1:0]} - {1'b0, in_low_ff};
      d_mag  = d_s[SW] ? SW'(~d_s + 1'b1) : d_s[SW-1:0];
      m_s    = {out_high_ff[OW-1], out_high_ff} - {out_low_ff[OW-1], out_low_ff};
      m_mag  = m_s[OW] ? OW'(~m_s + 1'b1) : m_s[OW-1:0];
      sp_s   = {1'b0, in_high_ff} - {1'b0, in_low_ff};
      sp_neg = sp_s[SW];
      sp_mag = sp_neg ? SW'(~sp_s + 1'b1) : sp_s[SW-1:0];
      if (sp_mag == '0) begin
         sp_mag = SW'(1);
      end

      q_s    = qneg_ff ? (PW + 1)'(~{1'b0, div_quot[PW-1:0]} + 1'b1)
                       : {1'b0, div_quot[PW-1:0]};
      v_full = {q_s[PW], q_s} + (PW + 2)'(signed'(out_low_ff));
      if (v_full[PW+1:NW-1] == '0 || v_full[PW+1:NW-1] == '1) begin
         v_sat = signed'(v_full[NW-1:0]);
      end else if (v_full[PW+1]) begin
         v_sat = signed'({1'b1, {(NW - 1){1'b0}}});
      end else begin
         v_sat = signed'({1'b0, {(NW - 1){1'b1}}});
      end

      weight   = (WTW'(idx_ff) << 3) - lpc_pkg::WEIGHT_BIAS;
      ws_mag   = ws_ff[WSW-1] ? WSW'(~ws_ff + 1'b1) : WSW'(ws_ff);
      vs_mag   = vs_ff[VSW-1] ? VSW'(~vs_ff + 1'b1) : VSW'(vs_ff);
      last     = (idx_ff == IDX_W'(NUM_SENSORS - 1));
      next_idx = done_ff ? '0 : idx_ff + IDX_W'(1);

      if (!eneg_ff) begin
         err_sat = (div_quot > DNUMW'(32767)) ? {1'b0, {(EW - 1){1'b1}}} : div_quot[EW-1:0];
      end else begin
         err_sat = (div_quot > DNUMW'(32768)) ? {1'b1, {(EW - 1){1'b0}}}
                                             : EW'(~div_quot[EW-1:0] + 1'b1);
      end

      div_start = 1'b0;
      div_num   = DNUMW'(prod_ff);
      div_den   = DDENW'(span_ff);
      if (state_ff == ST_MUL && mplier_ff == '0) begin
         div_start = 1'b1;
      end else if (state_ff == ST_LAST) begin
         div_start = last && (vs_ff != '0);
         div_num   = {ws_mag, 8'd0};
         div_den   = DDENW'(vs_mag);
      end

      out_free = !rsp_valid_ff || rsp_tready;
   end

   lpc_div #(
      .NUM_W (DNUMW),
      .DEN_W (DDENW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         ws_ff        <= '0;
         vs_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  mplier_ff <= d_mag;
                  mcand_ff  <= PW'(m_mag);
                  prod_ff   <= '0;
                  span_ff   <= sp_mag;
                  qneg_ff   <= d_s[SW] ^ m_s[OW] ^ sp_neg;
                  state_ff  <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (mplier_ff == '0) begin
                  state_ff <= ST_DIV_NORM;
               end else begin
                  if (mplier_ff[0]) begin
                     prod_ff <= prod_ff + mcand_ff;
                  end
                  mcand_ff  <= mcand_ff << 1;
                  mplier_ff <= mplier_ff >> 1;
               end
            end
            ST_DIV_NORM: begin
               if (div_done) begin
                  v_ff     <= v_sat;
                  state_ff <= ST_WMUL;
               end
            end
            ST_WMUL: begin
               wprod_ff <= v_ff * signed'(weight);
               vs_ff    <= vs_ff + VSW'(v_ff);
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               ws_ff    <= ws_ff + WSW'(wprod_ff);
               state_ff <= ST_LAST;
            end
            ST_LAST: begin
               done_ff   <= last;
               noline_ff <= last && (vs_ff == '0);
               err_ff    <= '0;
               eneg_ff   <= ws_ff[WSW-1] ^ vs_ff[VSW-1];
               state_ff  <= div_start ? ST_DIV_ERR : ST_OUT;
            end
            ST_DIV_ERR: begin
               if (div_done) begin
                  err_ff   <= err_sat;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_norm_ff   <= v_ff;
                  rsp_chan_ff   <= chan_off_ff + CW'(next_idx);
                  rsp_err_ff    <= err_ff;
                  rsp_last_ff   <= done_ff;
                  rsp_noline_ff <= noline_ff;
                  idx_ff        <= next_idx;
                  if (done_ff) begin
                     ws_ff <= '0;
                     vs_ff <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_err_ff, rsp_chan_ff, rsp_norm_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_noline_ff;

endmodule
